[rtl/core/cdad_pkg.sv]
// Shared types, constants and month-length helper for the date add-days unit.
// Used by cdad_alu and calendar_date_add_days_unit; no dependencies.
`default_nettype none

package cdad_pkg;

    localparam int DAY_COUNT_WIDTH = 16;
    localparam int YEAR_W          = 14;
    localparam int MONTH_W         = 4;
    localparam int MDAY_W          = 5;
    localparam int CENT_W          = 8;
    // Running day value: start day plus the full count.
    localparam int DAY_W           = DAY_COUNT_WIDTH + 1;
    localparam int OP_W            = (DAY_W > YEAR_W) ? DAY_W : YEAR_W;

    localparam logic [YEAR_W-1:0]  MAX_YEAR    = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  CENTURY     = YEAR_W'(100);
    localparam logic [YEAR_W-1:0]  LAST_OF_CENT = YEAR_W'(99);
    localparam logic [MONTH_W-1:0] JANUARY     = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY    = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DECEMBER    = MONTH_W'(12);
    localparam logic [MDAY_W-1:0]  LAST_DAY    = MDAY_W'(31);

    typedef logic [OP_W-1:0] t_op;
    typedef logic [DAY_W-1:0] t_day;

    typedef struct packed {
        logic [YEAR_W-1:0]          start_year;
        logic [MONTH_W-1:0]         start_month;
        logic [MDAY_W-1:0]          start_day;
        logic [DAY_COUNT_WIDTH-1:0] days_to_add;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [MDAY_W-1:0]  result_day;
        logic               input_valid;
        logic               year_overflow;
    } t_out;

    typedef struct packed {
        logic               use_div;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  rem;
        logic [CENT_W-1:0]  cent;
        logic [1:0]         year_lo;
        logic [MONTH_W-1:0] month;
    } t_alu_req;

    typedef struct packed {
        logic [OP_W:0]       diff;
        logic                borrow;
        logic                gt;
        logic                leap;
        logic [MDAY_W-1:0]   mlen;
    } t_alu_res;

    function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [MDAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = MDAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                   len = MDAY_W'(30);
            4'd2:                                      len = leap ? MDAY_W'(29)
                                                                  : MDAY_W'(28);
            default:                                   len = MDAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cdad_alu.sv]
// Shared subtract/compare unit with leap-year and month-length decode.
// Depends on cdad_pkg.
`default_nettype none

module cdad_alu (
    input  wire cdad_pkg::t_alu_req i_req,
    output cdad_pkg::t_alu_res      o_res
);

    logic                          leap;
    logic [cdad_pkg::MDAY_W-1:0]   mlen;
    cdad_pkg::t_op                 op_a;
    cdad_pkg::t_op                 op_b;
    logic [cdad_pkg::OP_W:0]       diff;

    // Year mod 400 is zero when mod 100 is zero and the century count is a multiple of 4.
    assign leap = ((i_req.year_lo == 2'd0) && (i_req.rem != '0)) ||
                  ((i_req.rem == '0) && (i_req.cent[1:0] == 2'd0));

    assign mlen = cdad_pkg::month_len(i_req.month, leap);

    assign op_a = i_req.use_div ? cdad_pkg::t_op'(i_req.rem) : cdad_pkg::t_op'(i_req.day);
    assign op_b = i_req.use_div ? cdad_pkg::t_op'(cdad_pkg::CENTURY)
                                : cdad_pkg::t_op'(mlen);

    assign diff = {1'b0, op_a} - {1'b0, op_b};

    always_comb begin
        o_res.diff   = diff;
        o_res.borrow = diff[cdad_pkg::OP_W];
        o_res.gt     = !diff[cdad_pkg::OP_W] && (diff != '0);
        o_res.leap   = leap;
        o_res.mlen   = mlen;
    end

endmodule

`default_nettype wire

[rtl/core/calendar_date_add_days_unit.sv]
// Gregorian date plus day count: sequencer around one shared subtract/compare unit.
// Depends on cdad_pkg and cdad_alu.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) takes one item: a start date
//   and a day count. Output channel (o_out_valid / i_out_stall / o_out) returns
//   one item per input: the new date, input_valid and year_overflow.
//   An invalid start date is echoed back with input_valid low.
//   The work runs in steps: split the year into century and remainder, check
//   the date, walk one month at a time until the day fits, and load the output
//   register. A full 16-bit count walks about 2155 months, so the month walk
//   through the single subtractor is the longest step.
//   One item is in work at a time; o_in_stall is high from acceptance until the
//   result has moved to the output register. The output register lets the
//   next item be accepted while a finished result still waits.
//   When the receiver stalls, o_out holds its item and a finished walk waits
//   for the register to free up.
//   Reset (i_rst_n low, synchronous) drops any item in work and any waiting
//   result.
`default_nettype none

module calendar_date_add_days_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire cdad_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output cdad_pkg::t_out     o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_WALK,
        S_DONE
    } t_state;

    t_state                                r_state;
    logic [cdad_pkg::YEAR_W-1:0]           r_year;
    logic [cdad_pkg::MONTH_W-1:0]          r_month;
    cdad_pkg::t_day                        r_day;
    logic [cdad_pkg::DAY_COUNT_WIDTH-1:0]  r_add;
    logic [cdad_pkg::YEAR_W-1:0]           r_rem;
    logic [cdad_pkg::CENT_W-1:0]           r_cent;
    logic                                  r_ok;
    logic                                  r_ovf;
    logic                                  r_out_vld;
    cdad_pkg::t_out                        r_out;

    cdad_pkg::t_alu_req                    alu_req;
    cdad_pkg::t_alu_res                    alu_res;
    logic                                  date_ok;
    logic                                  out_free;

    always_comb begin
        alu_req.use_div = (r_state == S_DIV);
        alu_req.day     = r_day;
        alu_req.rem     = r_rem;
        alu_req.cent    = r_cent;
        alu_req.year_lo = r_year[1:0];
        alu_req.month   = r_month;
    end

    cdad_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign date_ok = (r_year <= cdad_pkg::MAX_YEAR) &&
                     (r_month >= cdad_pkg::JANUARY) && (r_month <= cdad_pkg::DECEMBER) &&
                     (r_day != '0) &&
                     (r_day[cdad_pkg::MDAY_W-1:0] <= alu_res.mlen);

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            // Load a finished item, else drop the one just taken.
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_year  <= i_in.start_year;
                        r_month <= i_in.start_month;
                        r_day   <= cdad_pkg::t_day'(i_in.start_day);
                        r_add   <= i_in.days_to_add;
                        r_rem   <= i_in.start_year;
                        r_cent  <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Strip whole centuries off the year, one per cycle.
                    if (!alu_res.borrow) begin
                        r_rem  <= alu_res.diff[cdad_pkg::YEAR_W-1:0];
                        r_cent <= r_cent + 1'b1;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_ok <= date_ok;
                    if (date_ok) begin
                        r_day   <= r_day + cdad_pkg::t_day'(r_add);
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WALK: begin
                    if (alu_res.gt) begin
                        r_day <= alu_res.diff[cdad_pkg::DAY_W-1:0];
                        if (r_month == cdad_pkg::DECEMBER) begin
                            r_month <= cdad_pkg::JANUARY;
                            if (r_year == cdad_pkg::MAX_YEAR) begin
                                r_ovf   <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_year <= r_year + 1'b1;
                                // Keep century and remainder in step with the year.
                                if (r_rem == cdad_pkg::LAST_OF_CENT) begin
                                    r_rem  <= '0;
                                    r_cent <= r_cent + 1'b1;
                                end else begin
                                    r_rem <= r_rem + 1'b1;
                                end
                            end
                        end else begin
                            r_month <= r_month + 1'b1;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        if (r_ovf) begin
                            r_out.result_year  <= cdad_pkg::MAX_YEAR;
                            r_out.result_month <= cdad_pkg::DECEMBER;
                            r_out.result_day   <= cdad_pkg::LAST_DAY;
                        end else begin
                            r_out.result_year  <= r_year;
                            r_out.result_month <= r_month;
                            r_out.result_day   <= r_day[cdad_pkg::MDAY_W-1:0];
                        end
                        r_out.input_valid   <= r_ok;
                        r_out.year_overflow <= r_ovf;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DIV))
        else $error("accepted item did not start the century split");

    a_walk_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((r_month >= cdad_pkg::JANUARY) &&
                                 (r_month <= cdad_pkg::DECEMBER) &&
                                 (r_rem < cdad_pkg::CENTURY)))
        else $error("month walk left its legal range");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.year_overflow) |->
            ((o_out.result_year == cdad_pkg::MAX_YEAR) &&
             (o_out.result_month == cdad_pkg::DECEMBER) &&
             (o_out.result_day == cdad_pkg::LAST_DAY) && o_out.input_valid))
        else $error("overflow result not saturated");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !out_free) |=> (r_state == S_DONE))
        else $error("finished item left before the output register was free");

endmodule

`default_nettype wire

[bench/tb_calendar_date_add_days_unit.sv]
// Testbench for calendar_date_add_days_unit: directed date table, then random dates
// checked against an in-bench date-walk predictor under varied idle and stall.
// Depends on cdad_pkg and the RTL of calendar_date_add_days_unit.

module tb_calendar_date_add_days_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_W          = cdad_pkg::YEAR_W;
    localparam int MONTH_W         = cdad_pkg::MONTH_W;
    localparam int MDAY_W          = cdad_pkg::MDAY_W;
    localparam int DAY_COUNT_WIDTH = cdad_pkg::DAY_COUNT_WIDTH;

    // The slowest item splits a year near 9999 into centuries, then walks a full
    // 16-bit count month by month; the limit allows about three times 249 such items.
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE = 56;
    localparam int SEND_IDLE[4]  = '{0, 47, 0, 16};
    localparam int RECV_STALL[4] = '{0, 0, 47, 16};

    typedef struct {
        cdad_pkg::t_in  stim;
        bit             typed;
        cdad_pkg::t_out want;
    } t_date_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    cdad_pkg::t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    cdad_pkg::t_out o_out;

    cdad_pkg::t_out pending_dates[$];
    int   mismatch_cnt = 0;
    int   result_cnt = 0;
    int   cycle_cnt = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;

    calendar_date_add_days_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit year_has_feb29(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return year_has_feb29(yr) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Walk the date forward one month at a time, saturating past year 9999.
    function automatic cdad_pkg::t_out add_days_expect(input cdad_pkg::t_in d);
        int unsigned yr;
        int unsigned mo;
        longint unsigned dy;
        bit ovf;
        cdad_pkg::t_out r;
        yr  = d.start_year;
        mo  = d.start_month;
        dy  = d.start_day;
        ovf = 1'b0;
        r   = '0;
        if (yr > cdad_pkg::MAX_YEAR || mo < cdad_pkg::JANUARY || mo > cdad_pkg::DECEMBER ||
            dy == 0 || dy > days_in_month(yr, mo)) begin
            r.result_year  = d.start_year;
            r.result_month = d.start_month;
            r.result_day   = d.start_day;
            return r;
        end
        dy += d.days_to_add;
        while (dy > days_in_month(yr, mo)) begin
            dy -= days_in_month(yr, mo);
            mo++;
            if (mo > cdad_pkg::DECEMBER) begin
                mo = cdad_pkg::JANUARY;
                yr++;
                if (yr > cdad_pkg::MAX_YEAR) begin
                    ovf = 1'b1;
                    break;
                end
            end
        end
        if (ovf) begin
            r.result_year  = cdad_pkg::MAX_YEAR;
            r.result_month = cdad_pkg::DECEMBER;
            r.result_day   = cdad_pkg::LAST_DAY;
        end else begin
            r.result_year  = YEAR_W'(yr);
            r.result_month = MONTH_W'(mo);
            r.result_day   = MDAY_W'(dy);
        end
        r.input_valid   = 1'b1;
        r.year_overflow = ovf;
        return r;
    endfunction

    function automatic t_date_row mk_row(input int y, input int m, input int d, input int n,
                                         input bit typed, input int ry, input int rm,
                                         input int rd, input bit iv, input bit ov);
        t_date_row row;
        row.stim.start_year    = YEAR_W'(y);
        row.stim.start_month   = MONTH_W'(m);
        row.stim.start_day     = MDAY_W'(d);
        row.stim.days_to_add   = DAY_COUNT_WIDTH'(n);
        row.typed              = typed;
        row.want.result_year   = YEAR_W'(ry);
        row.want.result_month  = MONTH_W'(rm);
        row.want.result_day    = MDAY_W'(rd);
        row.want.input_valid   = iv;
        row.want.year_overflow = ov;
        return row;
    endfunction

    // Mostly short counts keep items quick; some span the full 16-bit range.
    function automatic logic [DAY_COUNT_WIDTH-1:0] pick_day_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DAY_COUNT_WIDTH'($urandom_range(0, 1500));
        else if (r < 90)
            return DAY_COUNT_WIDTH'($urandom_range(0, 65535));
        else
            return DAY_COUNT_WIDTH'($urandom_range(60000, 65535));
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("result %0d: %s mismatch, got %0d want %0d", result_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_date(input cdad_pkg::t_in stim, input cdad_pkg::t_out want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in       = stim;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_dates.push_back(want);
        @(negedge i_clk);
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_out
        cdad_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_dates.size() == 0) begin
                note_mismatch("unexpected item", o_out, 0);
            end else begin
                want = pending_dates.pop_front();
                if (o_out.result_year !== want.result_year)
                    note_mismatch("result_year", o_out.result_year, want.result_year);
                if (o_out.result_month !== want.result_month)
                    note_mismatch("result_month", o_out.result_month, want.result_month);
                if (o_out.result_day !== want.result_day)
                    note_mismatch("result_day", o_out.result_day, want.result_day);
                if (o_out.input_valid !== want.input_valid)
                    note_mismatch("input_valid", o_out.input_valid, want.input_valid);
                if (o_out.year_overflow !== want.year_overflow)
                    note_mismatch("year_overflow", o_out.year_overflow, want.year_overflow);
            end
            result_cnt++;
        end
    end

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[calendar_date_add_days_unit] ERROR");
        $finish;
    end

    initial begin
        t_date_row rows[$];
        cdad_pkg::t_in stim;
        int unsigned pick;
        int unsigned yr;
        int unsigned mo;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;

        // Typed rows: extremes, overflow and echoed invalid dates.
        rows.push_back(mk_row(0, 1, 1, 0, 1, 0, 1, 1, 1, 0));
        rows.push_back(mk_row(9999, 12, 31, 0, 1, 9999, 12, 31, 1, 0));
        rows.push_back(mk_row(9999, 12, 31, 1, 1, 9999, 12, 31, 1, 1));
        rows.push_back(mk_row(9999, 1, 1, 65535, 1, 9999, 12, 31, 1, 1));
        rows.push_back(mk_row(0, 0, 1, 5, 1, 0, 0, 1, 0, 0));
        rows.push_back(mk_row(2023, 13, 10, 7, 1, 2023, 13, 10, 0, 0));
        rows.push_back(mk_row(2023, 15, 31, 65535, 1, 2023, 15, 31, 0, 0));
        rows.push_back(mk_row(2023, 4, 0, 3, 1, 2023, 4, 0, 0, 0));
        rows.push_back(mk_row(2023, 4, 31, 3, 1, 2023, 4, 31, 0, 0));
        rows.push_back(mk_row(1900, 2, 29, 1, 1, 1900, 2, 29, 0, 0));
        rows.push_back(mk_row(2023, 2, 29, 0, 1, 2023, 2, 29, 0, 0));
        rows.push_back(mk_row(10000, 1, 1, 1, 1, 10000, 1, 1, 0, 0));
        rows.push_back(mk_row(16383, 15, 31, 65535, 1, 16383, 15, 31, 0, 0));
        rows.push_back(mk_row(2000, 2, 29, 0, 1, 2000, 2, 29, 1, 0));
        rows.push_back(mk_row(2024, 2, 29, 0, 1, 2024, 2, 29, 1, 0));
        rows.push_back(mk_row(0, 2, 29, 0, 1, 0, 2, 29, 1, 0));
        rows.push_back(mk_row(2023, 1, 31, 0, 1, 2023, 1, 31, 1, 0));
        // Predicted rows: leap boundaries, year wrap, long walks.
        rows.push_back(mk_row(2024, 2, 28, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(2023, 2, 28, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(2100, 2, 28, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(2023, 12, 31, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(2024, 1, 1, 366, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(0, 1, 1, 65535, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(1999, 12, 31, 65535, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(9821, 1, 1, 65535, 0, 0, 0, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k])
            offer_date(rows[k].stim, rows[k].typed ? rows[k].want : add_days_expect(rows[k].stim));

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct     = RECV_STALL[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    // Well-formed date, weighted toward centuries and the top year.
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        yr = $urandom_range(0, 9999);
                    else if (pick < 80)
                        yr = $urandom_range(0, 99) * 100;
                    else
                        yr = $urandom_range(9800, 9999);
                    mo = $urandom_range(1, 12);
                    stim.start_year  = YEAR_W'(yr);
                    stim.start_month = MONTH_W'(mo);
                    stim.start_day   = ($urandom_range(0, 4) == 0)
                                     ? MDAY_W'(days_in_month(yr, mo))
                                     : MDAY_W'($urandom_range(1, days_in_month(yr, mo)));
                end else if (pick < 93) begin
                    stim.start_year  = YEAR_W'($urandom_range(0, 16383));
                    stim.start_month = MONTH_W'($urandom_range(0, 15));
                    stim.start_day   = MDAY_W'($urandom_range(0, 31));
                end else begin
                    // Near miss: one day past the month end, or a bad month.
                    yr = $urandom_range(0, 9999);
                    mo = $urandom_range(1, 12);
                    stim.start_year  = YEAR_W'(yr);
                    stim.start_month = ($urandom_range(0, 1) == 0) ? MONTH_W'(mo)
                                     : MONTH_W'($urandom_range(13, 15));
                    stim.start_day   = MDAY_W'(days_in_month(yr, mo) + 1);
                end
                stim.days_to_add = pick_day_count();
                offer_date(stim, add_days_expect(stim));
            end
        end
        i_in_valid = 1'b0;

        while (pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        foreach (pending_dates[k])
            note_mismatch("missing item", 0, pending_dates[k].result_year);
        if (mismatch_cnt == 0) begin
            $display("[calendar_date_add_days_unit] OK");
        end else begin
            $display("[calendar_date_add_days_unit] ERROR");
        end
        $finish;
    end

endmodule
